### hdl/wtem_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helpers of the water tile edge mask stencil
package wtem_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int BANK_DEPTH   = MAX_WIDTH / 2;
  localparam int BANK_AW      = COL_W - 1;
  localparam int SLOTS        = 3;
  localparam int PAD_W        = 2 * ((ROW_W + 1) / 2);
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CHAR_W       = 8;
  localparam int TILE_W       = 5;

  localparam logic [WIDTH_REG_W-1:0]  MAP_WIDTH_RESET  = WIDTH_REG_W'(64);
  localparam logic [HEIGHT_REG_W-1:0] MAP_HEIGHT_RESET = HEIGHT_REG_W'(64);

  localparam logic [CHAR_W-1:0] CHAR_WATER_LO = 8'h77;
  localparam logic [CHAR_W-1:0] CHAR_WATER_UP = 8'h57;

  localparam logic [TILE_W-1:0] TILE_GRASS = 5'd16;

  // which results an item still owes, in output order
  localparam int PEND_ABOVE = 0;
  localparam int PEND_LEFT  = 1;
  localparam int PEND_SELF  = 2;
  localparam int PEND_W     = 3;

  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [1:0]       slot_t;
  typedef logic [SLOTS-1:0] col_bits_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row_flip;
    logic             water;
    slot_t            slot;
    logic             row_pos;
    logic             row_gt1;
    logic             last_col;
  } wtem_item_t;

  typedef struct packed {
    col_bits_t l2;
    col_bits_t l1;
    col_bits_t cc;
    col_bits_t r1;
  } wtem_window_t;

  function automatic slot_t mod3(input logic [ROW_W-1:0] v);
    logic [PAD_W-1:0] pad;
    logic [2:0]       acc;
    pad = PAD_W'(v);
    acc = 3'd0;
    for (int i = 0; i < PAD_W / 2; i++) begin
      acc = acc + {1'b0, pad[2*i +: 2]};
      if (acc >= 3'd3) begin
        acc = acc - 3'd3;
      end
    end
    return acc[1:0];
  endfunction

  function automatic slot_t slot_prev(input slot_t s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

### hdl/wtem_row_store.sv
`timescale 1ns / 1ps
// row stores: two column-interleaved banks holding three rows of water bits
module wtem_row_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [wtem_pkg::COL_W-1:0]  wr_col,
  input  wtem_pkg::slot_t             wr_slot,
  input  logic                        wr_bit,
  input  logic                        rd_en,
  input  logic [wtem_pkg::COL_W-1:0]  rd_col,
  output wtem_pkg::wtem_window_t      win
);

  wtem_pkg::col_bits_t bank_even [wtem_pkg::BANK_DEPTH];
  wtem_pkg::col_bits_t bank_odd  [wtem_pkg::BANK_DEPTH];

  logic [wtem_pkg::COL_W:0]     col_inc;
  logic [wtem_pkg::BANK_AW-1:0] even_a0;
  logic [wtem_pkg::BANK_AW-1:0] even_a1;
  logic [wtem_pkg::BANK_AW-1:0] odd_a0;
  logic [wtem_pkg::BANK_AW-1:0] odd_a1;
  logic [wtem_pkg::BANK_AW-1:0] wr_addr;

  wtem_pkg::col_bits_t even_q0;
  wtem_pkg::col_bits_t even_q1;
  wtem_pkg::col_bits_t odd_q0;
  wtem_pkg::col_bits_t odd_q1;
  logic                rd_odd;

  // even bank serves c-2/c or c-1/c+1, odd bank the other pair
  assign col_inc = {1'b0, rd_col} + (wtem_pkg::COL_W + 1)'(1);
  assign even_a1 = col_inc[wtem_pkg::COL_W-1:1];
  assign even_a0 = even_a1 - wtem_pkg::BANK_AW'(1);
  assign odd_a1  = rd_col[wtem_pkg::COL_W-1:1];
  assign odd_a0  = odd_a1 - wtem_pkg::BANK_AW'(1);
  assign wr_addr = wr_col[wtem_pkg::COL_W-1:1];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_col[0]) begin
      bank_even[wr_addr][wr_slot] <= wr_bit;
    end
    if (wr_en && wr_col[0]) begin
      bank_odd[wr_addr][wr_slot] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      even_q0 <= bank_even[even_a0];
      even_q1 <= bank_even[even_a1];
      odd_q0  <= bank_odd[odd_a0];
      odd_q1  <= bank_odd[odd_a1];
      rd_odd  <= rd_col[0];
    end
  end

  always_comb begin
    if (rd_odd) begin
      win.l2 = odd_q0;
      win.l1 = even_q0;
      win.cc = odd_q1;
      win.r1 = even_q1;
    end else begin
      win.l2 = even_q0;
      win.l1 = odd_q0;
      win.cc = even_q1;
      win.r1 = odd_q1;
    end
  end

endmodule

### hdl/wtem_result_seq.sv
`timescale 1ns / 1ps
// tile code stage: builds up to three results per item and drives the output register
module wtem_result_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load_item,
  input  wtem_pkg::wtem_item_t              item,
  input  logic [wtem_pkg::PEND_W-1:0]       item_pend,
  input  wtem_pkg::wtem_window_t            win,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wtem_pkg::TILE_W-1:0]       tile_code,
  output logic [wtem_pkg::COL_W-1:0]        map_col,
  output logic [wtem_pkg::ROW_W-1:0]        map_row,
  output logic                              run_last,
  output logic                              frame_last
);

  wtem_pkg::wtem_item_t          cur;
  logic [wtem_pkg::PEND_W-1:0]   pend;
  logic [wtem_pkg::PEND_W-1:0]   pend_rest;

  wtem_pkg::slot_t               s0;
  wtem_pkg::slot_t               s1p;
  wtem_pkg::slot_t               s2p;
  logic                          col_zero;
  logic                          col_one;
  logic [wtem_pkg::TILE_W-1:0]   tile_above;
  logic [wtem_pkg::TILE_W-1:0]   tile_left;
  logic [wtem_pkg::TILE_W-1:0]   tile_self;

  logic                          load;
  logic [wtem_pkg::TILE_W-1:0]   sel_tile;
  logic [wtem_pkg::COL_W-1:0]    sel_col;
  logic [wtem_pkg::ROW_W-1:0]    sel_row;
  logic                          sel_frame_last;

  assign s0       = cur.slot;
  assign s1p      = wtem_pkg::slot_prev(s0);
  assign s2p      = wtem_pkg::slot_prev(s1p);
  assign col_zero = (cur.col == '0);
  assign col_one  = (cur.col == wtem_pkg::COL_W'(1));

  // cell one row above the input
  always_comb begin
    if (!win.cc[s1p]) begin
      tile_above = wtem_pkg::TILE_GRASS;
    end else begin
      tile_above = {1'b0,
                    col_zero || !win.l1[s1p],
                    !cur.row_gt1 || !win.cc[s2p],
                    cur.last_col || !win.r1[s1p],
                    !cur.water};
    end
  end

  // last row: cell left of the input
  always_comb begin
    if (!win.l1[s0]) begin
      tile_left = wtem_pkg::TILE_GRASS;
    end else begin
      tile_left = {1'b0,
                   col_one || !win.l2[s0],
                   !cur.row_pos || !win.l1[s1p],
                   !cur.water,
                   1'b1};
    end
  end

  // last row, last column: the input cell itself
  always_comb begin
    if (!cur.water) begin
      tile_self = wtem_pkg::TILE_GRASS;
    end else begin
      tile_self = {1'b0,
                   col_zero || !win.l1[s0],
                   !cur.row_pos || !win.cc[s1p],
                   1'b1,
                   1'b1};
    end
  end

  always_comb begin
    if (pend[wtem_pkg::PEND_ABOVE]) begin
      sel_tile       = tile_above;
      sel_col        = cur.col;
      sel_row        = cur.row_flip + wtem_pkg::ROW_W'(1);
      sel_frame_last = 1'b0;
    end else if (pend[wtem_pkg::PEND_LEFT]) begin
      sel_tile       = tile_left;
      sel_col        = cur.col - wtem_pkg::COL_W'(1);
      sel_row        = cur.row_flip;
      sel_frame_last = 1'b0;
    end else begin
      sel_tile       = tile_self;
      sel_col        = cur.col;
      sel_row        = cur.row_flip;
      sel_frame_last = 1'b1;
    end
  end

  assign pend_rest = pend & (pend - wtem_pkg::PEND_W'(1));
  assign load      = (pend != '0) && (!out_valid || out_ready);
  assign in_ready  = (pend == '0) || (load && (pend_rest == '0));

  always_ff @(posedge clk) begin
    if (load_item) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load_item) begin
      pend <= item_pend;
    end else if (load) begin
      pend <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tile_code  <= sel_tile;
      map_col    <= sel_col;
      map_row    <= sel_row;
      run_last   <= (pend_rest == '0);
      frame_last <= sel_frame_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last)
    else $error("frame end beat is not the last beat of its item");

  a_frame_corner_edges: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> tile_code[4] || (tile_code[1] && tile_code[0]))
    else $error("bottom right water cell lacks right or down edge");

  a_ready_one_left: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> ($countones(pend) <= 1))
    else $error("new item taken while several results still owed");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

### hdl/water_tile_edge_mask_stencil.sv
`timescale 1ns / 1ps
// top level of the water tile edge mask stencil
// Takes one map cell per clock in raster order and returns one tile code beat per
// clock while in_valid and out_ready allow; an item is taken in the same cycle that
// the previous item's last beat is loaded, so cells flow back to back while the
// grid above the last row is streamed. Results of row r come out while row r+1
// is fed; on the last row every cell but the first owes two beats and the row's
// last cell three (one fewer each in a one-row grid), so there the output port
// sets the pace at one beat per clock while out_ready is high. The neighbor rows
// live in two column-interleaved banks of 128 x 3 bits with a registered read,
// read at four columns per cell and written once; they need no clearing after reset.
module water_tile_edge_mask_stencil (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  wtem_pkg::cfg_reg_t                  cfg_index,
  input  logic [wtem_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wtem_pkg::CHAR_W-1:0]         cell_char,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wtem_pkg::TILE_W-1:0]         tile_code,
  output logic [wtem_pkg::COL_W-1:0]          map_col,
  output logic [wtem_pkg::ROW_W-1:0]          map_row,
  output logic                                run_last,
  output logic                                frame_last
);

  logic [wtem_pkg::WIDTH_REG_W-1:0]  map_width;
  logic [wtem_pkg::HEIGHT_REG_W-1:0] map_height;
  logic [wtem_pkg::COL_W-1:0]        col_count;
  logic [wtem_pkg::ROW_W-1:0]        row_count;

  logic [wtem_pkg::COL_W-1:0]        w_last;
  logic [wtem_pkg::ROW_W-1:0]        h_last;
  logic [wtem_pkg::COL_W-1:0]        cur_col;
  logic [wtem_pkg::ROW_W-1:0]        cur_row;
  logic                              is_last_col;
  logic                              is_last_row;
  logic                              accept;

  wtem_pkg::wtem_item_t              item;
  logic [wtem_pkg::PEND_W-1:0]       item_pend;
  wtem_pkg::wtem_window_t            win;

  always_comb begin
    if (map_width == '0) begin
      w_last = '0;
    end else if (map_width > wtem_pkg::WIDTH_REG_W'(wtem_pkg::MAX_WIDTH)) begin
      w_last = wtem_pkg::COL_W'(wtem_pkg::MAX_WIDTH - 1);
    end else begin
      w_last = wtem_pkg::COL_W'(map_width - wtem_pkg::WIDTH_REG_W'(1));
    end
  end

  always_comb begin
    if (map_height == '0) begin
      h_last = '0;
    end else if (map_height > wtem_pkg::HEIGHT_REG_W'(wtem_pkg::MAX_HEIGHT)) begin
      h_last = wtem_pkg::ROW_W'(wtem_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = wtem_pkg::ROW_W'(map_height - wtem_pkg::HEIGHT_REG_W'(1));
    end
  end

  assign cur_col     = (col_count > w_last) ? w_last : col_count;
  assign cur_row     = (row_count > h_last) ? h_last : row_count;
  assign is_last_col = (cur_col == w_last);
  assign is_last_row = (cur_row == h_last);
  assign accept      = in_valid && in_ready;

  always_comb begin
    item.col      = cur_col;
    item.row_flip = h_last - cur_row;
    item.water    = (cell_char == wtem_pkg::CHAR_WATER_LO) ||
                    (cell_char == wtem_pkg::CHAR_WATER_UP);
    item.slot     = wtem_pkg::mod3(cur_row);
    item.row_pos  = (cur_row != '0);
    item.row_gt1  = (cur_row > wtem_pkg::ROW_W'(1));
    item.last_col = is_last_col;
  end

  always_comb begin
    item_pend                       = '0;
    item_pend[wtem_pkg::PEND_ABOVE] = (cur_row != '0);
    item_pend[wtem_pkg::PEND_LEFT]  = is_last_row && (cur_col != '0);
    item_pend[wtem_pkg::PEND_SELF]  = is_last_row && is_last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= wtem_pkg::MAP_WIDTH_RESET;
      map_height <= wtem_pkg::MAP_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        wtem_pkg::REG_MAP_WIDTH: begin
          map_width <= cfg_data[wtem_pkg::WIDTH_REG_W-1:0];
        end
        wtem_pkg::REG_MAP_HEIGHT: begin
          map_height <= cfg_data[wtem_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (is_last_col) begin
        col_count <= '0;
        row_count <= is_last_row ? '0 : cur_row + wtem_pkg::ROW_W'(1);
      end else begin
        col_count <= cur_col + wtem_pkg::COL_W'(1);
        row_count <= cur_row;
      end
    end
  end

  wtem_row_store u_row_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_col  (cur_col),
    .wr_slot (item.slot),
    .wr_bit  (item.water),
    .rd_en   (accept),
    .rd_col  (cur_col),
    .win     (win)
  );

  wtem_result_seq u_result_seq (
    .clk        (clk),
    .rst        (rst),
    .load_item  (accept),
    .item       (item),
    .item_pend  (item_pend),
    .win        (win),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tile_code  (tile_code),
    .map_col    (map_col),
    .map_row    (map_row),
    .run_last   (run_last),
    .frame_last (frame_last)
  );

endmodule
